>>> sv/lztd_pkg.sv
// ---------------------------------------------------------------------------
// lztd_pkg
// Shared types and constants of the LZ77 token decompressor.
// ---------------------------------------------------------------------------
package lztd_pkg;

    localparam int HISTORY_SIZE = 65536;
    localparam int HIST_AW      = $clog2(HISTORY_SIZE);
    localparam int BYTES_PER_RESULT = 8;

    localparam logic [7:0] MAGIC_0 = 8'h56;
    localparam logic [7:0] MAGIC_1 = 8'h4C;
    localparam logic [7:0] MAGIC_2 = 8'h5A;
    localparam logic [7:0] MAGIC_3 = 8'h31;
    localparam logic [2:0] FMT_MIN4 = 3'd3;
    localparam logic [3:0] VARINT_MAX = 4'd10;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEADER = 3'd1,
        ST_TOKEN  = 3'd2,
        ST_OFFSET = 3'd3,
        ST_LENGTH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_LIT   = 2'd1,
        CMD_MATCH = 2'd2
    } cmd_kind_t;

    // One decoded action handed from the parser to the copy engine.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         lit;
        logic [7:0]         len;
        logic [HIST_AW-1:0] off;
        logic               done;
        status_t            status;
    } cmd_t;

endpackage

>>> sv/lztd_ifs.sv
// ---------------------------------------------------------------------------
// lztd channel interfaces
// Valid/ready channels for compressed bytes, results and configuration.
// ---------------------------------------------------------------------------
interface lztd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;
    modport source (output valid, in_byte, end_of_stream, input ready);
    modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

interface lztd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_data;
    logic [3:0]  byte_count;
    logic        done_res;
    logic [2:0]  status;
    logic        run_last;
    modport source (output valid, out_data, byte_count, done_res, status, run_last,
                    input ready);
    modport sink   (input valid, out_data, byte_count, done_res, status, run_last,
                    output ready);
endinterface

interface lztd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] format_code;
    modport source (output valid, format_code, input ready);
    modport sink   (input valid, format_code, output ready);
endinterface

>>> sv/lztd_ram.sv
// ---------------------------------------------------------------------------
// lztd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lztd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/lztd_front.sv
// ---------------------------------------------------------------------------
// lztd_front
// Parses the header and tokens byte by byte and issues copy commands.
// ---------------------------------------------------------------------------
module lztd_front import lztd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    lztd_in_if.sink     stream,
    lztd_cfg_if.sink    cfg,
    input  logic        q_full,
    output logic        push,
    output cmd_t        cmd
);

    typedef enum logic [3:0] {
        PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3, PH_FORMAT, PH_LENGTH,
        PH_CTRL, PH_LITERAL, PH_OFFSET, PH_SKIP, PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [63:0] vint_reg, vint_next;
    logic [3:0]  vcnt_reg, vcnt_next;
    logic [63:0] exp_reg, exp_next;
    logic [63:0] prod_reg, prod_next;
    logic [7:0]  lit_reg, lit_next;
    logic [7:0]  mlen_reg, mlen_next;
    status_t     err_reg, err_next;
    logic [2:0]  format_reg;

    logic        accept;
    logic [7:0]  b;
    logic [6:0]  shamt;
    logic [63:0] vnew;
    logic [3:0]  vcnt_inc;
    logic        complete, overlong;
    logic [7:0]  magic_exp;

    assign stream.ready = !q_full;
    assign cfg.ready    = 1'b1;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.in_byte;

    assign shamt    = 7'({3'b000, vcnt_reg} * 7'd7);
    assign vnew     = vint_reg | ({57'd0, b[6:0]} << shamt);
    assign vcnt_inc = vcnt_reg + 4'd1;
    assign complete = !b[7];
    assign overlong = b[7] && (vcnt_inc >= VARINT_MAX);

    always_comb
    begin
        unique case (phase_reg)
            PH_MAGIC0: magic_exp = MAGIC_0;
            PH_MAGIC1: magic_exp = MAGIC_1;
            PH_MAGIC2: magic_exp = MAGIC_2;
            default:   magic_exp = MAGIC_3;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        vint_next  = vint_reg;
        vcnt_next  = vcnt_reg;
        exp_next   = exp_reg;
        prod_next  = prod_reg;
        lit_next   = lit_reg;
        mlen_next  = mlen_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.kind   = CMD_NONE;
        cmd.status = ST_OK;

        unique case (phase_reg)
            PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3:
            begin
                if (b != magic_exp)
                begin
                    err_next   = ST_HEADER;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
            end
            PH_FORMAT:
            begin
                if (b != {5'b00000, format_reg})
                begin
                    err_next   = ST_HEADER;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    phase_next = PH_LENGTH;
                    vint_next  = '0;
                    vcnt_next  = '0;
                end
            end
            PH_LENGTH:
            begin
                if (overlong)
                begin
                    err_next   = ST_HEADER;
                    phase_next = PH_ERROR;
                end
                else if (complete)
                begin
                    exp_next   = vnew;
                    phase_next = (vnew == 64'd0) ? PH_SKIP : PH_CTRL;
                end
                else
                begin
                    vint_next = vnew;
                    vcnt_next = vcnt_inc;
                end
            end
            PH_CTRL:
            begin
                if (!b[7])
                begin
                    lit_next   = {1'b0, b[6:0]} + 8'd1;
                    phase_next = PH_LITERAL;
                end
                else
                begin
                    mlen_next  = {1'b0, b[6:0]} + ((format_reg == FMT_MIN4) ? 8'd4 : 8'd3);
                    vint_next  = '0;
                    vcnt_next  = '0;
                    phase_next = PH_OFFSET;
                end
            end
            PH_LITERAL:
            begin
                prod_next = prod_reg + 64'd1;
                cmd.kind  = CMD_LIT;
                cmd.lit   = b;
                lit_next  = lit_reg - 8'd1;
                if (lit_reg == 8'd1)
                begin
                    phase_next = PH_CTRL;
                end
            end
            PH_OFFSET:
            begin
                if (overlong)
                begin
                    err_next   = ST_TOKEN;
                    phase_next = PH_ERROR;
                end
                else if (complete)
                begin
                    if (vnew == 64'd0 || vnew > prod_reg || vnew > 64'(HISTORY_SIZE))
                    begin
                        err_next   = ST_OFFSET;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        cmd.kind   = CMD_MATCH;
                        cmd.len    = mlen_reg;
                        cmd.off    = vnew[HIST_AW-1:0];
                        prod_next  = prod_reg + {56'd0, mlen_reg};
                        mlen_next  = '0;
                        phase_next = PH_CTRL;
                    end
                end
                else
                begin
                    vint_next = vnew;
                    vcnt_next = vcnt_inc;
                end
            end
            PH_SKIP, PH_ERROR:
            begin
            end
            default:
            begin
            end
        endcase

        if (stream.end_of_stream)
        begin
            cmd.done = 1'b1;
            priority if (phase_next == PH_ERROR)
                cmd.status = err_next;
            else if (phase_next == PH_SKIP)
                cmd.status = ST_OK;
            else if (phase_next == PH_CTRL)
                cmd.status = (prod_next == exp_next) ? ST_OK : ST_LENGTH;
            else if (phase_next == PH_LITERAL || phase_next == PH_OFFSET)
                cmd.status = ST_TOKEN;
            else
                cmd.status = ST_HEADER;
            phase_next = PH_MAGIC0;
            vint_next  = '0;
            vcnt_next  = '0;
            exp_next   = '0;
            prod_next  = '0;
            lit_next   = '0;
            mlen_next  = '0;
            err_next   = ST_OK;
        end
    end

    assign push = accept && (cmd.kind != CMD_NONE || stream.end_of_stream);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC0;
            vint_reg   <= '0;
            vcnt_reg   <= '0;
            exp_reg    <= '0;
            prod_reg   <= '0;
            lit_reg    <= '0;
            mlen_reg   <= '0;
            err_reg    <= ST_OK;
            format_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                format_reg <= cfg.format_code;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                vint_reg  <= vint_next;
                vcnt_reg  <= vcnt_next;
                exp_reg   <= exp_next;
                prod_reg  <= prod_next;
                lit_reg   <= lit_next;
                mlen_reg  <= mlen_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

>>> sv/lztd_cmd_fifo.sv
// ---------------------------------------------------------------------------
// lztd_cmd_fifo
// Two-entry command queue between the parser and the copy engine.
// ---------------------------------------------------------------------------
module lztd_cmd_fifo import lztd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic not_empty
);

    cmd_t       entry_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign head      = entry_reg[rd_reg];
    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> sv/lztd_back.sv
// ---------------------------------------------------------------------------
// lztd_back
// Copy engine: writes literals, copies matches from history, packs results.
// ---------------------------------------------------------------------------
module lztd_back import lztd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       not_empty,
    output logic       pop,
    lztd_out_if.source result
);

    typedef enum logic [2:0] {S_IDLE, S_LIT, S_RD, S_WR, S_STAT} state_t;

    state_t             state_reg;
    cmd_t               cur_reg;
    logic [7:0]         left_reg;
    logic [HIST_AW-1:0] wptr_reg;
    logic [63:0]        chunk_reg;
    logic [3:0]         cnt_reg;

    logic               ovalid_reg;
    logic [63:0]        odata_reg;
    logic [3:0]         ocnt_reg;
    logic               odone_reg;
    logic [2:0]         ostat_reg;
    logic               olast_reg;

    logic               can_emit, must_emit, step, emit;
    logic               ram_we, ram_re;
    logic [7:0]         ram_wdata, ram_rdata;
    logic [63:0]        chunk_add;

    assign can_emit  = !ovalid_reg || result.ready;
    assign must_emit = (cnt_reg == 4'(BYTES_PER_RESULT - 1)) || (left_reg == 8'd1);
    assign step      = (state_reg == S_WR) && (!must_emit || can_emit);
    assign emit      = (((state_reg == S_LIT) || (state_reg == S_STAT)) && can_emit)
                       || (step && must_emit);
    assign chunk_add = chunk_reg | ({56'd0, ram_rdata} << {cnt_reg[2:0], 3'b000});
    assign pop       = (state_reg == S_IDLE) && not_empty;

    assign ram_re    = state_reg == S_RD;
    assign ram_we    = ((state_reg == S_LIT) && can_emit) || step;
    assign ram_wdata = (state_reg == S_LIT) ? cur_reg.lit : ram_rdata;

    lztd_ram #(.WIDTH(8), .DEPTH(HISTORY_SIZE)) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (wptr_reg - cur_reg.off),
        .rdata (ram_rdata)
    );

    assign result.valid      = ovalid_reg;
    assign result.out_data   = odata_reg;
    assign result.byte_count = ocnt_reg;
    assign result.done_res   = odone_reg;
    assign result.status     = ostat_reg;
    assign result.run_last   = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            wptr_reg   <= '0;
            cur_reg    <= '0;
            left_reg   <= '0;
            chunk_reg  <= '0;
            cnt_reg    <= '0;
            odata_reg  <= '0;
            ocnt_reg   <= '0;
            odone_reg  <= 1'b0;
            ostat_reg  <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (not_empty)
                    begin
                        cur_reg   <= head;
                        left_reg  <= head.len;
                        chunk_reg <= '0;
                        cnt_reg   <= '0;
                        unique case (head.kind)
                            CMD_LIT:   state_reg <= S_LIT;
                            CMD_MATCH: state_reg <= S_RD;
                            default:   state_reg <= S_STAT;
                        endcase
                    end
                end
                S_LIT:
                begin
                    if (can_emit)
                    begin
                        wptr_reg   <= wptr_reg + 1'b1;
                        odata_reg  <= {56'd0, cur_reg.lit};
                        ocnt_reg   <= 4'd1;
                        odone_reg  <= 1'b0;
                        ostat_reg  <= ST_OK;
                        olast_reg  <= !cur_reg.done;
                        state_reg  <= cur_reg.done ? S_STAT : S_IDLE;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (step)
                    begin
                        wptr_reg <= wptr_reg + 1'b1;
                        left_reg <= left_reg - 8'd1;
                        if (must_emit)
                        begin
                            odata_reg  <= chunk_add;
                            ocnt_reg   <= cnt_reg + 4'd1;
                            odone_reg  <= 1'b0;
                            ostat_reg  <= ST_OK;
                            olast_reg  <= (left_reg == 8'd1) && !cur_reg.done;
                            chunk_reg  <= '0;
                            cnt_reg    <= '0;
                        end
                        else
                        begin
                            chunk_reg <= chunk_add;
                            cnt_reg   <= cnt_reg + 4'd1;
                        end
                        if (left_reg == 8'd1)
                            state_reg <= cur_reg.done ? S_STAT : S_IDLE;
                        else
                            state_reg <= S_RD;
                    end
                end
                S_STAT:
                begin
                    if (can_emit)
                    begin
                        odata_reg  <= '0;
                        ocnt_reg   <= '0;
                        odone_reg  <= 1'b1;
                        ostat_reg  <= cur_reg.status;
                        olast_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/lz77_token_decompressor.sv
// ---------------------------------------------------------------------------
// lz77_token_decompressor
// Byte-serial LZ77 token stream decoder with a 64 KiB history.
// ---------------------------------------------------------------------------
// The stream channel takes one compressed byte per item; end_of_stream marks
// the last byte. The result channel gives decoded data of one to eight bytes
// per item, and after the final byte a status item with done_res set. Data
// delivered before a non-zero status is to be discarded. The cfg channel
// writes format_code and is always ready; write it only while idle.
// The parser takes one byte per cycle whenever its two-entry command queue
// has room. The copy engine takes a command from the queue, then writes a
// literal, copies each match byte by a registered read of the history RAM
// followed by a write, or sends a status item. A literal or a lone status item
// passes through the queue, the engine's command register and its output
// register before it is valid on the result channel. When the receiver
// stalls, the engine holds its output register and the queue fills, after
// which the stream channel deasserts ready.
// Reset returns the decoder to the start of a header and format_code to zero;
// the history needs no clearing as offsets are checked before every read.
// ---------------------------------------------------------------------------
module lz77_token_decompressor import lztd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    lztd_in_if.sink    stream,
    lztd_cfg_if.sink   cfg,
    lztd_out_if.source result
);

    logic push, pop, q_full, q_not_empty;
    cmd_t cmd, head;

    lztd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .cfg    (cfg),
        .q_full (q_full),
        .push   (push),
        .cmd    (cmd)
    );

    lztd_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (cmd),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    lztd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (q_not_empty),
        .pop       (pop),
        .result    (result)
    );

    a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.done_res |->
            result.byte_count == 4'd0 && result.out_data == 64'd0 && result.run_last)
        else $error("status item carries data");

    a_data_item: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.done_res |->
            result.byte_count != 4'd0 && result.byte_count <= 4'(BYTES_PER_RESULT)
            && result.status == ST_OK)
        else $error("malformed data item");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("command queue overflow");

endmodule

>>> tb/sv/tb_lz77_token_decompressor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lz77_token_decompressor
// Self-checking testbench for the LZ77 token decompressor. A queue-fed
// driver offers compressed bytes, a clocked monitor compares every result
// item with the output of a behavioural decoder kept in the testbench. The
// run covers directed streams, then four phases of random streams under
// different format settings and idling patterns.
// ---------------------------------------------------------------------------
module tb_lz77_token_decompressor;
    import lztd_pkg::*;

    typedef enum logic [3:0] {
        DP_MAGIC0, DP_MAGIC1, DP_MAGIC2, DP_MAGIC3, DP_FORMAT, DP_LENGTH,
        DP_CTRL, DP_LITERAL, DP_OFFSET, DP_SKIP, DP_ERROR
    } dphase_t;

    typedef enum int { VI_MORE, VI_DONE, VI_OVERLONG } vint_res_t;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } stream_byte_t;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        done;
        logic [2:0]  status;
        logic        last;
    } decoded_t;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    lztd_in_if  stream ();
    lztd_out_if result ();
    lztd_cfg_if cfg ();

    lz77_token_decompressor DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .cfg    (cfg),
        .result (result)
    );

    // Decoder model state.
    logic [2:0]  fmt_reg;
    dphase_t     dphase;
    logic [63:0] vint_val;
    logic [3:0]  vint_cnt;
    logic [63:0] exp_len;
    logic [63:0] out_total;
    logic [7:0]  lit_left;
    logic [7:0]  copy_len;
    logic [2:0]  err_code;
    logic [7:0]  hist [0:HISTORY_SIZE-1];

    stream_byte_t byte_queue[$];
    decoded_t     decoded_queue[$];
    logic [7:0]   build_bytes[$];
    logic [7:0]   token_bytes[$];

    int  idle_mode;
    int  mismatches;
    int  cycles;
    logic in_taken;
    logic hold_req;
    int  hold_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- model ----------------
    function automatic vint_res_t vint_take(logic [7:0] b);
        logic [63:0] part;
        part = {57'd0, b[6:0]};
        vint_val = vint_val | (part << (7 * vint_cnt));
        if (!b[7])
            return VI_DONE;
        vint_cnt = vint_cnt + 4'd1;
        if (vint_cnt >= VARINT_MAX)
            return VI_OVERLONG;
        return VI_MORE;
    endfunction

    function automatic void push_decoded(logic [63:0] d, logic [3:0] c, logic dn,
                                         logic [2:0] st);
        decoded_t r;
        r.data = d;
        r.count = c;
        r.done = dn;
        r.status = st;
        r.last = 1'b0;
        decoded_queue.push_back(r);
    endfunction

    function automatic void store_out(logic [7:0] b);
        hist[out_total[HIST_AW-1:0]] = b;
        out_total = out_total + 64'd1;
    endfunction

    function automatic void clear_stream();
        dphase = DP_MAGIC0;
        vint_val = '0;
        vint_cnt = '0;
        exp_len = '0;
        out_total = '0;
        lit_left = '0;
        copy_len = '0;
        err_code = ST_OK;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic eos);
        int        n;
        vint_res_t v;
        logic [63:0] chunk;
        logic [63:0] off;
        logic [7:0]  hb;
        logic [HIST_AW-1:0] rd_idx;
        int          cnt;
        logic [2:0]  st;
        n = decoded_queue.size();
        case (dphase)
            DP_MAGIC0, DP_MAGIC1, DP_MAGIC2, DP_MAGIC3:
            begin
                if (b != (dphase == DP_MAGIC0 ? MAGIC_0 : dphase == DP_MAGIC1 ? MAGIC_1 :
                          dphase == DP_MAGIC2 ? MAGIC_2 : MAGIC_3))
                begin
                    err_code = ST_HEADER;
                    dphase = DP_ERROR;
                end
                else
                    dphase = dphase_t'(dphase + 1);
            end
            DP_FORMAT:
            begin
                if (b != {5'd0, fmt_reg})
                begin
                    err_code = ST_HEADER;
                    dphase = DP_ERROR;
                end
                else
                begin
                    dphase = DP_LENGTH;
                    vint_val = '0;
                    vint_cnt = '0;
                end
            end
            DP_LENGTH:
            begin
                v = vint_take(b);
                if (v == VI_OVERLONG)
                begin
                    err_code = ST_HEADER;
                    dphase = DP_ERROR;
                end
                else if (v == VI_DONE)
                begin
                    exp_len = vint_val;
                    dphase = (exp_len == 0) ? DP_SKIP : DP_CTRL;
                end
            end
            DP_CTRL:
            begin
                if (!b[7])
                begin
                    lit_left = {1'b0, b[6:0]} + 8'd1;
                    dphase = DP_LITERAL;
                end
                else
                begin
                    copy_len = {1'b0, b[6:0]} + (fmt_reg == FMT_MIN4 ? 8'd4 : 8'd3);
                    vint_val = '0;
                    vint_cnt = '0;
                    dphase = DP_OFFSET;
                end
            end
            DP_LITERAL:
            begin
                store_out(b);
                push_decoded({56'd0, b}, 4'd1, 1'b0, ST_OK);
                lit_left = lit_left - 8'd1;
                if (lit_left == 0)
                    dphase = DP_CTRL;
            end
            DP_OFFSET:
            begin
                v = vint_take(b);
                if (v == VI_OVERLONG)
                begin
                    err_code = ST_TOKEN;
                    dphase = DP_ERROR;
                end
                else if (v == VI_DONE)
                begin
                    off = vint_val;
                    if (off == 0 || off > out_total || off > HISTORY_SIZE)
                    begin
                        err_code = ST_OFFSET;
                        dphase = DP_ERROR;
                    end
                    else
                    begin
                        // Byte-by-byte copy, so an overlapping match repeats itself.
                        chunk = '0;
                        cnt = 0;
                        for (int k = 0; k < copy_len; k++)
                        begin
                            rd_idx = out_total[HIST_AW-1:0] - off[HIST_AW-1:0];
                            hb = hist[rd_idx];
                            store_out(hb);
                            chunk = chunk | ({56'd0, hb} << (8 * cnt));
                            cnt++;
                            if (cnt == BYTES_PER_RESULT)
                            begin
                                push_decoded(chunk, 4'(cnt), 1'b0, ST_OK);
                                chunk = '0;
                                cnt = 0;
                            end
                        end
                        if (cnt > 0)
                            push_decoded(chunk, 4'(cnt), 1'b0, ST_OK);
                        copy_len = '0;
                        dphase = DP_CTRL;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (eos)
        begin
            if (dphase == DP_ERROR)
                st = err_code;
            else if (dphase <= DP_LENGTH)
                st = ST_HEADER;
            else if (dphase == DP_SKIP)
                st = ST_OK;
            else if (dphase == DP_CTRL)
                st = (out_total == exp_len) ? ST_OK : ST_LENGTH;
            else
                st = ST_TOKEN;
            push_decoded('0, 4'd0, 1'b1, st);
            clear_stream();
        end
        if (decoded_queue.size() > n)
            decoded_queue[decoded_queue.size() - 1].last = 1'b1;
    endfunction

    // ---------------- stimulus building ----------------
    function automatic void push_varint(ref logic [7:0] q[$], input logic [63:0] val);
        logic [7:0] b;
        do
        begin
            b = {1'b0, val[6:0]};
            val = val >> 7;
            if (val != 0)
                b[7] = 1'b1;
            q.push_back(b);
        end
        while (val != 0);
    endfunction

    function automatic void push_header(logic [2:0] fmt);
        build_bytes.push_back(MAGIC_0);
        build_bytes.push_back(MAGIC_1);
        build_bytes.push_back(MAGIC_2);
        build_bytes.push_back(MAGIC_3);
        build_bytes.push_back({5'd0, fmt});
    endfunction

    // Well-formed tokens; returns the decoded length they produce.
    function automatic int build_tokens(int ntok);
        int p;
        int n;
        int low;
        p = 0;
        for (int t = 0; t < ntok; t++)
        begin
            if (p == 0 || $urandom_range(0, 1) == 0)
            begin
                n = ($urandom_range(0, 40) == 0) ? 128 : $urandom_range(1, 6);
                token_bytes.push_back(8'(n - 1));
                for (int i = 0; i < n; i++)
                    token_bytes.push_back(8'($urandom_range(0, 255)));
                p += n;
            end
            else
            begin
                low = ($urandom_range(0, 15) == 0) ? 127 : $urandom_range(0, 9);
                token_bytes.push_back(8'h80 | 8'(low));
                push_varint(token_bytes, 64'($urandom_range(1, p)));
                p += low + (fmt_reg == FMT_MIN4 ? 4 : 3);
            end
        end
        return p;
    endfunction

    task automatic submit_build();
        stream_byte_t s;
        for (int i = 0; i < build_bytes.size(); i++)
        begin
            s.data = build_bytes[i];
            s.eos = (i == build_bytes.size() - 1);
            decode_byte(s.data, s.eos);
            byte_queue.push_back(s);
        end
    endtask

    // Builds one stream, mostly well-formed, and returns its item count.
    task automatic gen_stream(output int items);
        int kind;
        int p;
        int cut;
        build_bytes.delete();
        token_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 97)
        begin
            repeat ($urandom_range(1, 6))
                build_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            p = build_tokens($urandom_range(1, 4));
            if (kind >= 86 && kind < 90)
            begin
                // Match whose offset points outside the data produced so far.
                token_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                case ($urandom_range(0, 2))
                    0: push_varint(token_bytes, 64'd0);
                    1: push_varint(token_bytes, 64'(p + $urandom_range(1, 300)));
                    default: push_varint(token_bytes, 64'(HISTORY_SIZE + 4464));
                endcase
                void'(build_tokens(1));
            end
            else if (kind >= 90 && kind < 93)
            begin
                token_bytes.push_back(8'h80);
                repeat (10)
                    token_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end
            push_header((kind >= 95) ? fmt_reg + 3'd1 : fmt_reg);
            if (kind >= 93 && kind < 95)
            begin
                repeat (10)
                    build_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end
            else if (kind >= 60 && kind < 68)
            begin
                build_bytes.push_back(8'h00);
            end
            else
            begin
                push_varint(build_bytes, ($urandom_range(0, 9) == 0) ?
                            64'($urandom_range(1, 400)) : 64'(p));
            end
            foreach (token_bytes[i])
                build_bytes.push_back(token_bytes[i]);
            if (kind >= 68 && kind < 78)
            begin
                cut = $urandom_range(1, build_bytes.size() - 1);
                while (build_bytes.size() > cut)
                    void'(build_bytes.pop_back());
            end
            if (kind >= 95 && $urandom_range(0, 1) == 0)
                build_bytes[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
        end
        items = build_bytes.size();
        submit_build();
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || stream.valid || decoded_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(logic [2:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.format_code <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        fmt_reg = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // ---------------- driver ----------------
    always @(posedge clk)
        in_taken <= stream.valid && stream.ready;

    always @(negedge clk)
    begin
        stream_byte_t s;
        int idle_pct;
        if (rst_n && (!stream.valid || in_taken))
        begin
            idle_pct = (idle_mode == 1) ? 84 : (idle_mode == 3) ? 9 : 0;
            if (byte_queue.size() != 0 && $urandom_range(1, 100) > idle_pct)
            begin
                s = byte_queue.pop_front();
                stream.in_byte <= s.data;
                stream.end_of_stream <= s.eos;
                stream.valid <= 1'b1;
            end
            else
                stream.valid <= 1'b0;
        end
    end

    // ---------------- receiver ----------------
    always @(negedge clk)
    begin
        int stall_pct;
        stall_pct = (idle_mode == 2) ? 84 : (idle_mode == 3) ? 9 : 0;
        if (hold_req && hold_left == 0)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        result.ready <= !(hold_left > 1) && ($urandom_range(1, 100) > stall_pct);
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        decoded_t e;
        cycles <= cycles + 1;
        if (rst_n && result.valid && result.ready)
        begin
            if (decoded_queue.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result item: data %h count %0d done %b status %0d",
                             result.out_data, result.byte_count, result.done_res,
                             result.status);
            end
            else
            begin
                e = decoded_queue.pop_front();
                if (result.out_data !== e.data || result.byte_count !== e.count ||
                    result.done_res !== e.done || result.status !== e.status ||
                    result.run_last !== e.last)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result mismatch: expected %h/%0d/%b/%0d/%b got %h/%0d/%b/%0d/%b",
                                 e.data, e.count, e.done, e.status, e.last,
                                 result.out_data, result.byte_count, result.done_res,
                                 result.status, result.run_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        int items;
        int phase_items;
        logic [2:0] phase_fmt [0:3];
        clk = 1'b0;
        stream.valid = 1'b0;
        stream.in_byte = '0;
        stream.end_of_stream = 1'b0;
        cfg.valid = 1'b0;
        cfg.format_code = '0;
        result.ready = 1'b0;
        idle_mode = 0;
        mismatches = 0;
        cycles = 0;
        in_taken = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        fmt_reg = '0;
        clear_stream();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme literals, overlapping and longest match, zero
        // length with ignored payload, wrong magic, ten-byte length varint.
        build_bytes = '{8'h56, 8'h4C, 8'h5A, 8'h31, 8'h00, 8'h88, 8'h01,
                        8'h01, 8'h00, 8'hFF, 8'h81, 8'h01, 8'hFF, 8'h02};
        submit_build();
        build_bytes = '{8'h56, 8'h4C, 8'h5A, 8'h31, 8'h00, 8'h00, 8'hAA};
        submit_build();
        build_bytes = '{8'h56, 8'h4D};
        submit_build();
        build_bytes = '{8'h56, 8'h4C, 8'h5A, 8'h31, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
        submit_build();
        wait_idle();

        phase_fmt[0] = FMT_MIN4;
        phase_fmt[1] = 3'd7;
        phase_fmt[2] = 3'd0;
        phase_fmt[3] = 3'($urandom_range(0, 7));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_format(phase_fmt[ph]);
            idle_mode = ph;
            phase_items = 0;
            while (phase_items < 90)
            begin
                gen_stream(items);
                phase_items += items;
                // Let the receiver hold off while the sender keeps offering.
                if (ph == 0 && phase_items > 30 && !hold_req)
                begin
                    hold_req = 1'b1;
                    @(posedge clk);
                    @(posedge clk);
                    hold_req = 1'b0;
                end
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
